### design/utc_cal_pkg.sv
`timescale 1ns / 1ps

package utc_cal_pkg;

  // Pipeline depth, input register through output register
  localparam int unsigned NUM_STAGES = 10;

  // Largest accepted time stamp: 9999-12-31 23:59:59
  localparam logic [63:0] LAST_SECOND = 64'd253402300799;

  // 86400 = 675 * 2^7; the low 7 bits pass straight to the remainder
  localparam int unsigned DAY_SHIFT     = 7;
  localparam logic [9:0]  DAY_ODD       = 10'd675;
  localparam logic [21:0] DAY_ODD_RECIP = 22'd3181457;   // floor(2^31 / 675)

  // Day count offset and Gregorian cycle lengths
  localparam logic [21:0] DAYS_1601_TO_1970 = 22'd134774;
  localparam logic [17:0] DAYS_400Y         = 18'd146097;
  localparam logic [14:0] RECIP_400Y        = 15'd29398;  // floor(2^32 / 146097)
  localparam logic [17:0] DAYS_100Y         = 18'd36524;
  localparam logic [10:0] DAYS_4Y           = 11'd1461;
  localparam logic [9:0]  RECIP_4Y          = 10'd717;    // floor(2^20 / 1461)
  localparam logic [10:0] DAYS_1Y           = 11'd365;

  // Weekday: day 0 was a Thursday
  localparam logic [21:0] WEEKDAY_OFFSET = 22'd4;
  localparam logic [2:0]  DAYS_WEEK      = 3'd7;
  localparam logic [22:0] RECIP_7        = 23'd4793490;  // floor(2^25 / 7)

  // Time of day
  localparam logic [11:0] SECS_HOUR   = 12'd3600;
  localparam logic [10:0] RECIP_HOUR  = 11'd1165;        // floor(2^22 / 3600)
  localparam logic [5:0]  SECS_MIN    = 6'd60;
  localparam logic [12:0] RECIP_MIN   = 13'd4369;        // floor(2^18 / 60)

  // Year offset: 1601 - 1900
  localparam logic [13:0] YEAR_BIAS = 14'd299;

  localparam int unsigned NUM_MONTHS = 12;

  // First day of each month in a common year, zero-based
  localparam logic [8:0] MONTH_START [NUM_MONTHS] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // First day of a month, shifted by one after February in a leap year
  function automatic logic [8:0] month_first_day(input logic [3:0] mon, input logic leap);
    logic [8:0] base;
    logic       shift;
    base  = (mon < 4'(NUM_MONTHS)) ? MONTH_START[mon] : 9'd0;
    shift = leap && (mon >= 4'd2);
    return base + 9'(shift);
  endfunction

endpackage

### design/unix_seconds_to_utc_calendar_core.sv
`timescale 1ns / 1ps
// Each input transaction passes through every register stage to the output register.
// Throughput: one transaction per cycle; ten register stages holding constant-reciprocal
// multiplies, multiply-back and correction steps, and compare steps.
// A stall on the output holds the whole pipeline in place.
// Reset (rst, synchronous, active high) clears the stage valid bits only.
module unix_seconds_to_utc_calendar_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [63:0] unix_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic [5:0]         second,
  output logic [5:0]         minute,
  output logic [4:0]         hour,
  output logic [4:0]         day_of_month,
  output logic [3:0]         month,
  output logic [12:0]        year_since_1900,
  output logic [8:0]         day_of_year,
  output logic [2:0]         weekday
);

  logic [utc_cal_pkg::NUM_STAGES-1:0] vld;
  logic                               adv;

  // Stage registers
  logic        s1_err;
  logic [30:0] s1_x;
  logic [6:0]  s1_lo;
  logic [21:0] s1_qde;

  logic        s2_err;
  logic [21:0] s2_days;
  logic [16:0] s2_rem;

  logic        s3_err;
  logic [21:0] s3_d;
  logic [4:0]  s3_q400e;
  logic [21:0] s3_w;
  logic [18:0] s3_we;
  logic [16:0] s3_rem;
  logic [4:0]  s3_he;

  logic        s4_err;
  logic [4:0]  s4_q400;
  logic [17:0] s4_r400;
  logic [2:0]  s4_wday;
  logic [4:0]  s4_hour;
  logic [11:0] s4_rs;

  logic        s5_err;
  logic [4:0]  s5_q400;
  logic [1:0]  s5_q100;
  logic [15:0] s5_r100;
  logic [2:0]  s5_wday;
  logic [4:0]  s5_hour;
  logic [11:0] s5_rs;
  logic [5:0]  s5_me;

  logic        s6_err;
  logic [4:0]  s6_q400;
  logic [1:0]  s6_q100;
  logic [15:0] s6_r100;
  logic [4:0]  s6_q4e;
  logic [2:0]  s6_wday;
  logic [4:0]  s6_hour;
  logic [5:0]  s6_min;
  logic [5:0]  s6_sec;

  logic        s7_err;
  logic [4:0]  s7_q400;
  logic [1:0]  s7_q100;
  logic [4:0]  s7_q4;
  logic [10:0] s7_r4;
  logic [2:0]  s7_wday;
  logic [4:0]  s7_hour;
  logic [5:0]  s7_min;
  logic [5:0]  s7_sec;

  logic        s8_err;
  logic [4:0]  s8_q400;
  logic [1:0]  s8_q100;
  logic [4:0]  s8_q4;
  logic [1:0]  s8_q1;
  logic [8:0]  s8_yday;
  logic        s8_leap;
  logic [2:0]  s8_wday;
  logic [4:0]  s8_hour;
  logic [5:0]  s8_min;
  logic [5:0]  s8_sec;

  logic        s9_err;
  logic [12:0] s9_year;
  logic [8:0]  s9_yday;
  logic [3:0]  s9_mon;
  logic        s9_leap;
  logic [2:0]  s9_wday;
  logic [4:0]  s9_hour;
  logic [5:0]  s9_min;
  logic [5:0]  s9_sec;

  // Combinational values per stage
  logic        c1_err;
  logic [30:0] c1_x;
  logic [52:0] c1_prod;

  logic [31:0] c2_prod;
  logic [31:0] c2_diff;
  logic [10:0] c2_r;
  logic        c2_fix;
  logic [10:0] c2_rfix;
  logic [21:0] c2_days;

  logic [21:0] c3_d;
  logic [36:0] c3_p400;
  logic [21:0] c3_w;
  logic [44:0] c3_pw;
  logic [27:0] c3_ph;

  logic [22:0] c4_p400;
  logic [22:0] c4_d400;
  logic [18:0] c4_r400;
  logic        c4_fix400;
  logic [18:0] c4_r400fix;
  logic [21:0] c4_pw;
  logic [21:0] c4_dw;
  logic [3:0]  c4_wr;
  logic [3:0]  c4_wfix;
  logic [16:0] c4_ph;
  logic [16:0] c4_dh;
  logic [12:0] c4_hr;
  logic        c4_hfix;
  logic [12:0] c4_hrfix;

  logic [1:0]  c5_q100;
  logic [17:0] c5_sub;
  logic [17:0] c5_r100;
  logic [24:0] c5_pm;

  logic [25:0] c6_pq4;
  logic [11:0] c6_pm;
  logic [11:0] c6_dm;
  logic [6:0]  c6_mr;
  logic        c6_mfix;
  logic [6:0]  c6_mrfix;

  logic [15:0] c7_p;
  logic [15:0] c7_d;
  logic [11:0] c7_r;
  logic        c7_fix;
  logic [11:0] c7_rfix;

  logic [1:0]  c8_q1;
  logic [10:0] c8_sub;
  logic [10:0] c8_yday;
  logic        c8_leap;

  logic [13:0] c9_year;
  logic [3:0]  c9_mon;

  logic [8:0]  c10_dom;

  // Global advance: the whole pipeline holds while the result waits
  assign adv       = !(vld[utc_cal_pkg::NUM_STAGES-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[utc_cal_pkg::NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[utc_cal_pkg::NUM_STAGES-2:0], in_valid};
    end
  end

  // Stage 1: range check, estimate of seconds / 86400
  always_comb begin
    c1_err  = $unsigned(unix_seconds) > utc_cal_pkg::LAST_SECOND;
    c1_x    = unix_seconds[37:utc_cal_pkg::DAY_SHIFT];
    c1_prod = 53'(c1_x) * 53'(utc_cal_pkg::DAY_ODD_RECIP);
  end

  // Stage 2: correct day count, form second of day
  always_comb begin
    c2_prod = 32'(s1_qde) * 32'(utc_cal_pkg::DAY_ODD);
    c2_diff = 32'(s1_x) - c2_prod;
    c2_r    = c2_diff[10:0];
    c2_fix  = c2_r >= 11'(utc_cal_pkg::DAY_ODD);
    c2_rfix = c2_fix ? c2_r - 11'(utc_cal_pkg::DAY_ODD) : c2_r;
    c2_days = s1_qde + 22'(c2_fix);
  end

  // Stage 3: estimates for 400-year cycle, weekday and hour
  always_comb begin
    c3_d    = s2_days + utc_cal_pkg::DAYS_1601_TO_1970;
    c3_p400 = 37'(c3_d) * 37'(utc_cal_pkg::RECIP_400Y);
    c3_w    = s2_days + utc_cal_pkg::WEEKDAY_OFFSET;
    c3_pw   = 45'(c3_w) * 45'(utc_cal_pkg::RECIP_7);
    c3_ph   = 28'(s2_rem) * 28'(utc_cal_pkg::RECIP_HOUR);
  end

  // Stage 4: correct 400-year cycle, weekday and hour
  always_comb begin
    c4_p400    = 23'(s3_q400e) * 23'(utc_cal_pkg::DAYS_400Y);
    c4_d400    = 23'(s3_d) - c4_p400;
    c4_r400    = c4_d400[18:0];
    c4_fix400  = c4_r400 >= 19'(utc_cal_pkg::DAYS_400Y);
    c4_r400fix = c4_fix400 ? c4_r400 - 19'(utc_cal_pkg::DAYS_400Y) : c4_r400;

    c4_pw      = 22'(s3_we) * 22'(utc_cal_pkg::DAYS_WEEK);
    c4_dw      = s3_w - c4_pw;
    c4_wr      = c4_dw[3:0];
    c4_wfix    = (c4_wr >= 4'(utc_cal_pkg::DAYS_WEEK)) ?
                 c4_wr - 4'(utc_cal_pkg::DAYS_WEEK) : c4_wr;

    c4_ph      = 17'(s3_he) * 17'(utc_cal_pkg::SECS_HOUR);
    c4_dh      = s3_rem - c4_ph;
    c4_hr      = c4_dh[12:0];
    c4_hfix    = c4_hr >= 13'(utc_cal_pkg::SECS_HOUR);
    c4_hrfix   = c4_hfix ? c4_hr - 13'(utc_cal_pkg::SECS_HOUR) : c4_hr;
  end

  // Stage 5: 100-year cycle by compare (last century of a cycle keeps the leap day)
  always_comb begin
    if (s4_r400 >= 18'(3 * utc_cal_pkg::DAYS_100Y)) begin
      c5_q100 = 2'd3;
    end else if (s4_r400 >= 18'(2 * utc_cal_pkg::DAYS_100Y)) begin
      c5_q100 = 2'd2;
    end else if (s4_r400 >= utc_cal_pkg::DAYS_100Y) begin
      c5_q100 = 2'd1;
    end else begin
      c5_q100 = 2'd0;
    end
    c5_sub  = 18'(c5_q100) * utc_cal_pkg::DAYS_100Y;
    c5_r100 = s4_r400 - c5_sub;
    c5_pm   = 25'(s4_rs) * 25'(utc_cal_pkg::RECIP_MIN);
  end

  // Stage 6: estimate 4-year cycle, correct minute
  always_comb begin
    c6_pq4   = 26'(s5_r100) * 26'(utc_cal_pkg::RECIP_4Y);
    c6_pm    = 12'(s5_me) * 12'(utc_cal_pkg::SECS_MIN);
    c6_dm    = s5_rs - c6_pm;
    c6_mr    = c6_dm[6:0];
    c6_mfix  = c6_mr >= 7'(utc_cal_pkg::SECS_MIN);
    c6_mrfix = c6_mfix ? c6_mr - 7'(utc_cal_pkg::SECS_MIN) : c6_mr;
  end

  // Stage 7: correct 4-year cycle
  always_comb begin
    c7_p    = 16'(s6_q4e) * 16'(utc_cal_pkg::DAYS_4Y);
    c7_d    = s6_r100 - c7_p;
    c7_r    = c7_d[11:0];
    c7_fix  = c7_r >= 12'(utc_cal_pkg::DAYS_4Y);
    c7_rfix = c7_fix ? c7_r - 12'(utc_cal_pkg::DAYS_4Y) : c7_r;
  end

  // Stage 8: year within the 4-year cycle; leap when it is the fourth year,
  // unless it closes a century that does not close a 400-year cycle
  always_comb begin
    if (s7_r4 >= 11'(3 * utc_cal_pkg::DAYS_1Y)) begin
      c8_q1 = 2'd3;
    end else if (s7_r4 >= 11'(2 * utc_cal_pkg::DAYS_1Y)) begin
      c8_q1 = 2'd2;
    end else if (s7_r4 >= utc_cal_pkg::DAYS_1Y) begin
      c8_q1 = 2'd1;
    end else begin
      c8_q1 = 2'd0;
    end
    c8_sub  = 11'(c8_q1) * utc_cal_pkg::DAYS_1Y;
    c8_yday = s7_r4 - c8_sub;
    c8_leap = (c8_q1 == 2'd3) && ((s7_q4 != 5'd24) || (s7_q100 == 2'd3));
  end

  // Stage 9: assemble year, find month by compare against month starts
  always_comb begin
    c9_year = 14'(s8_q400) * 14'd400 + 14'(s8_q100) * 14'd100
            + {7'd0, s8_q4, 2'b00} + 14'(s8_q1) - utc_cal_pkg::YEAR_BIAS;
    c9_mon  = 4'd0;
    for (int k = 1; k < utc_cal_pkg::NUM_MONTHS; k++) begin
      if (s8_yday >= utc_cal_pkg::month_first_day(4'(k), s8_leap)) begin
        c9_mon = 4'(k);
      end
    end
  end

  // Stage 10: day of month
  always_comb begin
    c10_dom = s9_yday - utc_cal_pkg::month_first_day(s9_mon, s9_leap) + 9'd1;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_err  <= c1_err;
      s1_x    <= c1_x;
      s1_lo   <= unix_seconds[utc_cal_pkg::DAY_SHIFT-1:0];
      s1_qde  <= c1_prod[52:31];

      s2_err  <= s1_err;
      s2_days <= c2_days;
      s2_rem  <= {c2_rfix[9:0], s1_lo};

      s3_err   <= s2_err;
      s3_d     <= c3_d;
      s3_q400e <= c3_p400[36:32];
      s3_w     <= c3_w;
      s3_we    <= c3_pw[43:25];
      s3_rem   <= s2_rem;
      s3_he    <= c3_ph[26:22];

      s4_err  <= s3_err;
      s4_q400 <= s3_q400e + 5'(c4_fix400);
      s4_r400 <= c4_r400fix[17:0];
      s4_wday <= c4_wfix[2:0];
      s4_hour <= s3_he + 5'(c4_hfix);
      s4_rs   <= c4_hrfix[11:0];

      s5_err  <= s4_err;
      s5_q400 <= s4_q400;
      s5_q100 <= c5_q100;
      s5_r100 <= c5_r100[15:0];
      s5_wday <= s4_wday;
      s5_hour <= s4_hour;
      s5_rs   <= s4_rs;
      s5_me   <= c5_pm[23:18];

      s6_err  <= s5_err;
      s6_q400 <= s5_q400;
      s6_q100 <= s5_q100;
      s6_r100 <= s5_r100;
      s6_q4e  <= c6_pq4[24:20];
      s6_wday <= s5_wday;
      s6_hour <= s5_hour;
      s6_min  <= s5_me + 6'(c6_mfix);
      s6_sec  <= c6_mrfix[5:0];

      s7_err  <= s6_err;
      s7_q400 <= s6_q400;
      s7_q100 <= s6_q100;
      s7_q4   <= s6_q4e + 5'(c7_fix);
      s7_r4   <= c7_rfix[10:0];
      s7_wday <= s6_wday;
      s7_hour <= s6_hour;
      s7_min  <= s6_min;
      s7_sec  <= s6_sec;

      s8_err  <= s7_err;
      s8_q400 <= s7_q400;
      s8_q100 <= s7_q100;
      s8_q4   <= s7_q4;
      s8_q1   <= c8_q1;
      s8_yday <= c8_yday[8:0];
      s8_leap <= c8_leap;
      s8_wday <= s7_wday;
      s8_hour <= s7_hour;
      s8_min  <= s7_min;
      s8_sec  <= s7_sec;

      s9_err  <= s8_err;
      s9_year <= c9_year[12:0];
      s9_yday <= s8_yday;
      s9_mon  <= c9_mon;
      s9_leap <= s8_leap;
      s9_wday <= s8_wday;
      s9_hour <= s8_hour;
      s9_min  <= s8_min;
      s9_sec  <= s8_sec;

      // Output register; out-of-range inputs report status with zeroed fields
      if (s9_err) begin
        status          <= 1'b1;
        second          <= '0;
        minute          <= '0;
        hour            <= '0;
        day_of_month    <= '0;
        month           <= '0;
        year_since_1900 <= '0;
        day_of_year     <= '0;
        weekday         <= '0;
      end else begin
        status          <= 1'b0;
        second          <= s9_sec;
        minute          <= s9_min;
        hour            <= s9_hour;
        day_of_month    <= c10_dom[4:0];
        month           <= s9_mon;
        year_since_1900 <= s9_year;
        day_of_year     <= s9_yday;
        weekday         <= s9_wday;
      end
    end
  end

endmodule

### design/utc_cal_checker.sv
`timescale 1ns / 1ps

module utc_cal_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [63:0] unix_seconds,
  input logic               out_valid,
  input logic               out_stall,
  input logic               status,
  input logic [5:0]         second,
  input logic [5:0]         minute,
  input logic [4:0]         hour,
  input logic [4:0]         day_of_month,
  input logic [3:0]         month,
  input logic [12:0]        year_since_1900,
  input logic [8:0]         day_of_year,
  input logic [2:0]         weekday
);

  // A stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(second)
      && $stable(minute) && $stable(hour) && $stable(day_of_month)
      && $stable(month) && $stable(year_since_1900) && $stable(day_of_year)
      && $stable(weekday))
    else $error("stalled result changed");

  // Input side only stalls while a finished result is held back
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Error transaction carries zeroed fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> second == 6'd0 && minute == 6'd0 && hour == 5'd0
      && day_of_month == 5'd0 && month == 4'd0 && year_since_1900 == 13'd0
      && day_of_year == 9'd0 && weekday == 3'd0)
    else $error("error result with nonzero fields");

  // Good transaction fields are in calendar range
  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> second < 6'd60 && minute < 6'd60 && hour < 5'd24
      && day_of_month != 5'd0 && month < 4'd12 && weekday < 3'd7
      && day_of_year <= 9'd365 && year_since_1900 >= 13'd70
      && year_since_1900 <= 13'd8099)
    else $error("result field out of calendar range");

endmodule

bind unix_seconds_to_utc_calendar_core utc_cal_checker u_utc_cal_checker (.*);
